// ===== design/fca_pkg.sv =====
`default_nettype none

package fca_pkg;

    // request kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_FAT32 = 3'd1;
    localparam logic [2:0] KIND_FAT16 = 3'd2;
    localparam logic [2:0] KIND_FAT12 = 3'd3;
    localparam logic [2:0] KIND_DIR   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_SECTOR_LOG2  = 3'd0;
    localparam logic [2:0] REG_CLUSTER_LOG2 = 3'd1;
    localparam logic [2:0] REG_RESERVED     = 3'd2;
    localparam logic [2:0] REG_FAT_COUNT    = 3'd3;
    localparam logic [2:0] REG_SECT_PER_FAT = 3'd4;
    localparam logic [2:0] REG_ROOT_ENTRIES = 3'd5;
    localparam logic [2:0] REG_TOTAL        = 3'd6;

    localparam logic [3:0]  SECTOR_LOG2_MIN   = 4'd9;
    localparam logic [3:0]  SECTOR_LOG2_MAX   = 4'd12;
    localparam logic [3:0]  DIR_ENTRY_LOG2    = 4'd5;
    localparam logic [31:0] DATA_START_RESET  = 32'd32;

    typedef struct packed {
        logic [3:0]  sector_log2;
        logic [2:0]  cluster_log2;
        logic [15:0] reserved;
        logic [31:0] fat_size;
        logic [31:0] total;
        logic [31:0] data_start;
    } geom_t;

    typedef struct packed {
        logic [31:0] sector;
        logic [11:0] byte_offset;
        logic [31:0] mirror_sector;
        logic        odd_nibble;
        logic [31:0] cluster_total;
        logic [31:0] data_start;
    } result_t;

endpackage

`default_nettype wire

// ===== design/fca_geometry.sv =====
`default_nettype none

module fca_geometry
    import fca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output geom_t            geom
);

    logic [3:0]  sector_log2_reg;
    logic [2:0]  cluster_log2_reg;
    logic [15:0] reserved_reg;
    logic [2:0]  fat_count_reg;
    logic [31:0] fat_size_reg;
    logic [15:0] root_entries_reg;
    logic [31:0] total_reg;
    logic [31:0] data_start_reg;
    logic [31:0] data_start_next;

    logic [3:0]  sl_eff;
    logic [11:0] smask;
    logic [21:0] root_bytes;
    logic [21:0] root_secs;
    logic [31:0] fat_span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_log2_reg     <= 4'd9;
            cluster_log2_reg    <= 3'd0;
            reserved_reg        <= 16'd32;
            fat_count_reg       <= 3'd2;
            fat_size_reg        <= 32'd0;
            root_entries_reg    <= 16'd0;
            total_reg           <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SECTOR_LOG2:  sector_log2_reg     <= cfg_data[3:0];
                REG_CLUSTER_LOG2: cluster_log2_reg    <= cfg_data[2:0];
                REG_RESERVED:     reserved_reg        <= cfg_data[15:0];
                REG_FAT_COUNT:    fat_count_reg       <= cfg_data[2:0];
                REG_SECT_PER_FAT: fat_size_reg        <= cfg_data;
                REG_ROOT_ENTRIES: root_entries_reg    <= cfg_data[15:0];
                REG_TOTAL:        total_reg           <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (sector_log2_reg < SECTOR_LOG2_MIN)
            sl_eff = SECTOR_LOG2_MIN;
        else if (sector_log2_reg > SECTOR_LOG2_MAX)
            sl_eff = SECTOR_LOG2_MAX;
        else
            sl_eff = sector_log2_reg;
    end

    // root directory sectors: round the byte count up to whole sectors
    assign smask      = 12'((13'd1 << sl_eff) - 13'd1);
    assign root_bytes = 22'({root_entries_reg, 5'b0}) + 22'(smask);
    assign root_secs  = root_bytes >> sl_eff;
    assign fat_span   = 32'(32'(fat_count_reg) * fat_size_reg);

    assign data_start_next = 32'(reserved_reg) + fat_span + 32'(root_secs);

    // follows the registers, updating in the cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_start_reg <= DATA_START_RESET;
        else
            data_start_reg <= data_start_next;
    end

    assign geom.sector_log2     = sl_eff;
    assign geom.cluster_log2    = cluster_log2_reg;
    assign geom.reserved        = reserved_reg;
    assign geom.fat_size        = fat_size_reg;
    assign geom.total           = total_reg;
    assign geom.data_start      = data_start_reg;

endmodule

`default_nettype wire

// ===== design/fca_map.sv =====
`default_nettype none

module fca_map
    import fca_pkg::*;
(
    input  geom_t            geom,
    input  wire logic [2:0]  kind,
    input  wire logic [27:0] cluster,
    input  wire logic [15:0] entry_index,
    output result_t          res
);

    logic [11:0] smask;
    logic [31:0] clus_sector;
    logic [2:0]  per_log2;
    logic [15:0] idx_mask;
    logic [15:0] entry_sect;
    logic [15:0] c16;
    logic [31:0] fat_off;
    logic [31:0] fat_sector;
    logic [11:0] fat_byte;

    assign smask       = 12'((13'd1 << geom.sector_log2) - 13'd1);
    assign clus_sector = ((32'(cluster) - 32'd2) << geom.cluster_log2) + geom.data_start;
    assign per_log2    = 3'(geom.sector_log2 - DIR_ENTRY_LOG2);
    assign idx_mask    = 16'((17'd1 << per_log2) - 17'd1);
    assign entry_sect  = entry_index >> per_log2;
    assign c16         = cluster[15:0];

    always_comb
    begin
        case (kind)
            KIND_FAT32: fat_off = {2'b0, cluster, 2'b0};
            KIND_FAT16: fat_off = {15'b0, c16, 1'b0};
            KIND_FAT12: fat_off = 32'(17'(c16) + 17'(c16 >> 1));
            default:    fat_off = 32'd0;
        endcase
    end

    assign fat_sector = 32'(geom.reserved) + (fat_off >> geom.sector_log2);
    assign fat_byte   = fat_off[11:0] & smask;

    always_comb
    begin
        res.sector        = 32'd0;
        res.byte_offset   = 12'd0;
        res.mirror_sector = 32'd0;
        res.odd_nibble    = 1'b0;
        res.cluster_total = (geom.total - geom.data_start) >> geom.cluster_log2;
        res.data_start    = geom.data_start;
        case (kind)
            KIND_DATA:
            begin
                res.sector = clus_sector;
            end
            KIND_FAT32, KIND_FAT16, KIND_FAT12:
            begin
                res.sector        = fat_sector;
                res.byte_offset   = fat_byte;
                res.mirror_sector = fat_sector + geom.fat_size;
                res.odd_nibble    = (kind == KIND_FAT12) ? c16[0] : 1'b0;
            end
            KIND_DIR:
            begin
                res.sector      = clus_sector + 32'(entry_sect);
                res.byte_offset = 12'({entry_index & idx_mask, 5'b0});
            end
            default:
            begin
                res.sector = 32'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/fat_cluster_address_unit.sv =====
// FAT cluster address unit.
// Configuration: write cfg_data to register cfg_index while cfg_we is high.
// Registers are sector size log2, cluster size log2, reserved sectors, FAT
// count, sectors per FAT, root entries and total sectors. Write only while
// the block holds no request; the derived first data sector settles in the
// cycle after the last write.
// Request channel: in_valid/in_ready carries kind, cluster and entry_index.
// Result channel: out_valid/out_ready carries sector, byte_offset,
// mirror_sector, odd_nibble, cluster_total and data_start.
// Path: an accepted beat is held in the input register and moves into the
// result register once that register is free; the receiver takes it from
// there. Throughput: one beat per cycle while out_ready stays high; the
// input register and the result register each hold one beat, so a stalled
// receiver backs the channel up after two beats and in_ready drops.
// Reset returns all configuration registers to the boot defaults (512-byte
// sectors, one sector per cluster, 32 reserved sectors, two FAT copies) and
// empties both stages.
`default_nettype none

module fat_cluster_address_unit
    import fca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [27:0] cluster,
    input  wire logic [15:0] entry_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      sector,
    output logic [11:0]      byte_offset,
    output logic [31:0]      mirror_sector,
    output logic             odd_nibble,
    output logic [31:0]      cluster_total,
    output logic [31:0]      data_start
);

    geom_t   geom;
    result_t res;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [2:0]  s1_kind_reg;
    logic [27:0] s1_cluster_reg;
    logic [15:0] s1_entry_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    logic        in_fire;
    logic        out_free;

    fca_geometry u_geometry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    fca_map u_map (
        .geom        (geom),
        .kind        (s1_kind_reg),
        .cluster     (s1_cluster_reg),
        .entry_index (s1_entry_reg),
        .res         (res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg    <= kind;
            s1_cluster_reg <= cluster;
            s1_entry_reg   <= entry_index;
        end
        // advance the held request into the result register
        if (out_free && s1_valid_reg)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign sector        = res_reg.sector;
    assign byte_offset   = res_reg.byte_offset;
    assign mirror_sector = res_reg.mirror_sector;
    assign odd_nibble    = res_reg.odd_nibble;
    assign cluster_total = res_reg.cluster_total;
    assign data_start    = res_reg.data_start;

endmodule

`default_nettype wire

// ===== design/fca_checker.sv =====
`default_nettype none

module fca_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] sector,
    input wire logic [11:0] byte_offset,
    input wire logic [31:0] mirror_sector,
    input wire logic        odd_nibble
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sector)
            && $stable(byte_offset) && $stable(mirror_sector) && $stable(odd_nibble))
    else $error("result beat changed while stalled");

    // input side backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

    // an accepted request is followed by a valid beat on the result port, past the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted request produced no result");

endmodule

bind fat_cluster_address_unit fca_checker u_fca_checker (.*);

`default_nettype wire
